>>> rtl/baro_temp_press_compensation_assert.svh
// assertion macros shared by the barometric compensation rtl
// expects signals named clk and rst_n in the including scope
`ifndef BARO_TEMP_PRESS_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESS_COMPENSATION_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define BTPC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("btpc: same-cycle check failed");

// condition must hold in the cycle after the trigger
`define BTPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("btpc: next-cycle check failed");

`endif

>>> rtl/btpc_pkg.sv
// shared types, constants and helpers for the barometric compensation block
// no dependencies
package btpc_pkg;

  // queue geometry, same for both queues
  localparam int QDEPTH = 16;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = QAW + 1;

  // register indexes on the config port
  localparam logic [1:0] REG_LOW  = 2'd0;
  localparam logic [1:0] REG_MID  = 2'd1;
  localparam logic [1:0] REG_HIGH = 2'd2;

  // reciprocal of ten, exact floor for dividends below 2^47
  localparam int          RECIP10_SHIFT = 50;
  localparam logic [46:0] RECIP10       = 47'd112589990684263;

  typedef struct packed {
    logic        [15:0] t1;
    logic        [15:0] t2;
    logic signed [7:0]  t3;
    logic signed [15:0] p1;
    logic signed [15:0] p2;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic        [15:0] p5;
    logic        [15:0] p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;
  } coef_t;

  typedef struct packed {
    logic        [23:0] up;
    logic signed [27:0] tl;
    logic signed [20:0] temp;
    logic        [31:0] press;
    logic               clamped;
  } item_t;

  typedef struct packed {
    logic           avail;
    logic           empty;
    logic [QCW-1:0] cnt;
    logic [QCW-1:0] occ;
  } qstat_t;

  // calibration bytes 0..20, byte 0 in bits 7..0
  function automatic coef_t decode_coef(input logic [167:0] cal);
    coef_t c;
    c.t1  = cal[15:0];
    c.t2  = cal[31:16];
    c.t3  = cal[39:32];
    c.p1  = cal[55:40];
    c.p2  = cal[71:56];
    c.p3  = cal[79:72];
    c.p4  = cal[87:80];
    c.p5  = cal[103:88];
    c.p6  = cal[119:104];
    c.p7  = cal[127:120];
    c.p8  = cal[135:128];
    c.p9  = cal[151:136];
    c.p10 = cal[159:152];
    c.p11 = cal[167:160];
    return c;
  endfunction

  // signed divide by 2^k, truncating toward zero
  function automatic logic signed [63:0] sdiv_p2(input logic signed [63:0] x,
                                                  input int unsigned k);
    logic [63:0] bias;
    bias = x[63] ? ((64'd1 << k) - 64'd1) : 64'd0;
    return (x + $signed(bias)) >>> k;
  endfunction

endpackage

>>> rtl/baro_temp_press_compensation.sv
// top level of the barometric temperature and pressure compensation block
// depends on btpc_pkg, btpc_queue, btpc_front, btpc_back and the assert header
//
//   channel   handshake          payload
//   input     push / full        in_raw_pressure, in_raw_temperature
//   result    pop / empty        out_temperature_centi, out_pressure_centi,
//                                out_pressure_clamped
//   config    psel/penable/...   paddr (8-byte stride), pwdata / prdata 64 bits
//
// one transaction per cycle sustained while results are popped. a result
// becomes visible after passing the temperature pipeline, the middle queue,
// the pressure pipeline and the result queue. each queue holds 16 entries
// and grants credits for items still in flight, so behind a stalled consumer
// the result queue takes 16 transactions and full rises once 32 transactions
// are outstanding. reset clears control state and the calibration.
module baro_temp_press_compensation (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               push,
  output logic               full,
  input  logic [23:0]        in_raw_pressure,
  input  logic [23:0]        in_raw_temperature,
  // result channel
  input  logic               pop,
  output logic               empty,
  output logic signed [20:0] out_temperature_centi,
  output logic [31:0]        out_pressure_centi,
  output logic               out_pressure_clamped,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

`include "baro_temp_press_compensation_assert.svh"

  logic [63:0]       cal_low_r, cal_mid_r;
  logic [39:0]       cal_high_r;
  logic              cfg_wr;
  btpc_pkg::coef_t   coef;

  logic              in_acc, front_push, mid_pop, back_push;
  btpc_pkg::item_t   front_item, mid_head, back_item, out_head;
  btpc_pkg::qstat_t  mid_stat, out_stat;

  // calibration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_low_r  <= '0;
      cal_mid_r  <= '0;
      cal_high_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        btpc_pkg::REG_LOW:  cal_low_r  <= pwdata;
        btpc_pkg::REG_MID:  cal_mid_r  <= pwdata;
        btpc_pkg::REG_HIGH: cal_high_r <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[4:3])
      btpc_pkg::REG_LOW:  prdata = cal_low_r;
      btpc_pkg::REG_MID:  prdata = cal_mid_r;
      btpc_pkg::REG_HIGH: prdata = {24'd0, cal_high_r};
      default:            prdata = '0;
    endcase
  end

  assign coef = btpc_pkg::decode_coef({cal_high_r, cal_mid_r, cal_low_r});

  // front side
  assign full   = !mid_stat.avail;
  assign in_acc = push && !full;

  btpc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_acc),
    .raw_pressure    (in_raw_pressure),
    .raw_temperature (in_raw_temperature),
    .coef            (coef),
    .push            (front_push),
    .item            (front_item)
  );

  btpc_queue u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsv       (in_acc),
    .push      (front_push),
    .push_item (front_item),
    .pop       (mid_pop),
    .head      (mid_head),
    .stat      (mid_stat)
  );

  // back side takes work only when the result queue has a credit
  assign mid_pop = !mid_stat.empty && out_stat.avail;

  btpc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (mid_pop),
    .in_item (mid_head),
    .coef    (coef),
    .push    (back_push),
    .item    (back_item)
  );

  btpc_queue u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsv       (mid_pop),
    .push      (back_push),
    .push_item (back_item),
    .pop       (pop && !empty),
    .head      (out_head),
    .stat      (out_stat)
  );

  // result ports
  assign empty                 = out_stat.empty;
  assign out_temperature_centi = out_head.temp;
  assign out_pressure_centi    = out_head.press;
  assign out_pressure_clamped  = out_head.clamped;

  // checks
  `BTPC_ASSERT_SAME(a_mid_push_reserved, front_push, mid_stat.occ < mid_stat.cnt)
  `BTPC_ASSERT_SAME(a_out_push_reserved, back_push, out_stat.occ < out_stat.cnt)
  `BTPC_ASSERT_SAME(a_out_credit_covers, 1'b1, out_stat.occ <= out_stat.cnt)
  `BTPC_ASSERT_NEXT(a_accept_reserves, in_acc, mid_stat.cnt != '0)

endmodule

>>> rtl/btpc_queue.sv
// credit-managed result queue between pipeline parts
// depends on btpc_pkg
module btpc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rsv,
  input  logic             push,
  input  btpc_pkg::item_t  push_item,
  input  logic             pop,
  output btpc_pkg::item_t  head,
  output btpc_pkg::qstat_t stat
);

  btpc_pkg::item_t              mem_r [btpc_pkg::QDEPTH];
  logic [btpc_pkg::QAW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [btpc_pkg::QCW-1:0]     cnt_r, cnt_nxt, occ_r, occ_nxt;

  // credits cover items in flight plus items stored
  always_comb begin
    cnt_nxt = cnt_r + btpc_pkg::QCW'(rsv) - btpc_pkg::QCW'(pop);
    occ_nxt = occ_r + btpc_pkg::QCW'(push) - btpc_pkg::QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      occ_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      occ_r <= occ_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.avail = (cnt_r < btpc_pkg::QCW'(btpc_pkg::QDEPTH));
  assign stat.empty = (occ_r == '0);
  assign stat.cnt   = cnt_r;
  assign stat.occ   = occ_r;

endmodule

>>> rtl/btpc_front.sv
// front pipeline: takes raw samples, computes linear and centi temperature
// depends on btpc_pkg
module btpc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [23:0]       raw_pressure,
  input  logic [23:0]       raw_temperature,
  input  btpc_pkg::coef_t   coef,
  output logic              push,
  output btpc_pkg::item_t   item
);

  localparam int NSTG = 6;

  logic [NSTG-1:0]     vld_r;
  logic [23:0]         up_r [NSTG];
  logic [23:0]         ut0_r;
  logic signed [25:0]  a1_r, a1_nxt;
  logic signed [42:0]  bt2_r, bt2_nxt, bt3_r;
  logic signed [51:0]  sq2_r, sq2_nxt;
  logic signed [59:0]  ct3_r, ct3_nxt;
  logic signed [27:0]  tl4_r, tl5_r;
  logic signed [20:0]  temp5_r;
  logic signed [63:0]  sum4, tl_full, t25, temp_full;

  // temperature arithmetic per stage
  always_comb begin
    a1_nxt    = $signed({2'b00, ut0_r}) - $signed({2'b00, coef.t1, 8'h00});
    bt2_nxt   = $signed({1'b0, coef.t2}) * a1_r;
    sq2_nxt   = a1_r * a1_r;
    ct3_nxt   = sq2_r * coef.t3;
    sum4      = (64'(bt3_r) <<< 18) + 64'(ct3_r);
    tl_full   = btpc_pkg::sdiv_p2(sum4, 32);
    t25       = 64'(tl4_r) * 64'sd25;
    temp_full = btpc_pkg::sdiv_p2(t25, 14);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-2:0], accept};
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    up_r[0] <= raw_pressure;
    for (int i = 1; i < NSTG; i++) up_r[i] <= up_r[i-1];
    ut0_r   <= raw_temperature;
    a1_r    <= a1_nxt;
    bt2_r   <= bt2_nxt;
    sq2_r   <= sq2_nxt;
    bt3_r   <= bt2_r;
    ct3_r   <= ct3_nxt;
    tl4_r   <= tl_full[27:0];
    tl5_r   <= tl4_r;
    temp5_r <= temp_full[20:0];
  end

  assign push         = vld_r[NSTG-1];
  assign item.up      = up_r[NSTG-1];
  assign item.tl      = tl5_r;
  assign item.temp    = temp5_r;
  assign item.press   = '0;
  assign item.clamped = 1'b0;

endmodule

>>> rtl/btpc_back.sv
// back pipeline: offset, sensitivity and pressure polynomial, then clamp
// depends on btpc_pkg
module btpc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  btpc_pkg::item_t   in_item,
  input  btpc_pkg::coef_t   coef,
  output logic              push,
  output btpc_pkg::item_t   item
);

  localparam int NSTG = 13;
  localparam int NUP  = 9;

  logic [NSTG-1:0]    vld_r;
  logic [23:0]        up_r [NUP];
  logic signed [20:0] temp_r [NSTG];

  logic signed [27:0] tl0_r, tl1_r;
  logic signed [55:0] sq1_r, sq1_nxt;
  logic signed [44:0] m6_1_r, m6_1_nxt, m2_1_r, m2_1_nxt;
  logic signed [35:0] m10_1_r, m10_1_nxt;
  logic [47:0]        ff1_r, ff1_nxt;
  logic signed [16:0] p1m, p2m;

  logic [49:0]        bb;
  logic signed [53:0] cplo2_r, cplo2_nxt, cphi2_r, cphi2_nxt;
  logic signed [63:0] e7_2_r, e7_2_nxt, d3_2_r, d3_2_nxt;
  logic signed [36:0] ce2_r, ce2_nxt;
  logic signed [56:0] f11_2_r, f11_2_nxt;
  logic signed [63:0] f6_2_r, e2_2_r;

  logic signed [63:0] cp3_r, cp3_nxt, dd3_r, o1_3_r, o1_3_nxt, s1_3_r, s1_3_nxt;
  logic signed [63:0] e7_3_r, d3_3_r, f11_div;
  logic signed [61:0] dd_full;
  logic signed [40:0] b11_3_r;

  logic signed [63:0] c4_r, d4_r, c11_4_r, o2_4_r, s2_4_r;
  logic signed [65:0] c11_full;

  logic signed [71:0] d8_full, b4_full;
  logic signed [63:0] d8_5_r, b4_5_r, cc5_r, o2_5_r, s2_5_r, absd;
  logic [45:0]        mag;
  logic [69:0]        qlo5_r, qlo5_nxt, qhi5_r, qhi5_nxt;
  logic               neg5_r, neg6_r;

  logic [92:0]        qsum;
  logic [42:0]        q6_r;
  logic signed [63:0] d6_r, b4d6_r, cc6_r, o2_6_r, s2_6_r;

  logic signed [43:0] dq7_r, dq7_nxt;
  logic signed [63:0] o3_7_r, s3_7_r, cc7_r;

  logic signed [68:0] ee_full;
  logic signed [63:0] ee8_r, off4_8_r, cc8_r, sa_div;
  logic signed [39:0] sa8_r;

  logic signed [64:0] aa_full;
  logic signed [63:0] e9_r, aa9_r, off4_9_r, cc9_r;

  logic signed [63:0] e10_r, sum1_10_r, cc10_r;
  logic signed [63:0] sum11_r;

  logic [44:0]        lo25;
  logic [33:0]        pf;
  logic [31:0]        press12_r, press_nxt;
  logic               clamp12_r, clamp_nxt;

  // products and sums per stage
  always_comb begin
    // stage 1: squares and tl products
    sq1_nxt   = tl0_r * tl0_r;
    m6_1_nxt  = $signed({1'b0, coef.p6}) * tl0_r;
    p2m       = $signed({coef.p2[15], coef.p2}) - 17'sd16384;
    p1m       = $signed({coef.p1[15], coef.p1}) - 17'sd16384;
    m2_1_nxt  = p2m * tl0_r;
    m10_1_nxt = coef.p10 * tl0_r;
    ff1_nxt   = up_r[0] * up_r[0];
    // stage 2: split product of tl^2/64 and tl, narrow-coefficient products
    bb        = sq1_r[55:6];
    cplo2_nxt = $signed({1'b0, bb[24:0]}) * tl1_r;
    cphi2_nxt = $signed({1'b0, bb[49:25]}) * tl1_r;
    e7_2_nxt  = sq1_r * coef.p7;
    d3_2_nxt  = sq1_r * coef.p3;
    ce2_nxt   = 37'(m10_1_r) + (37'(coef.p9) <<< 16);
    f11_2_nxt = $signed({1'b0, ff1_r}) * coef.p11;
    // stage 3: recombine, first offset and sensitivity terms
    cp3_nxt   = 64'(cplo2_r) + (64'(cphi2_r) <<< 25);
    dd_full   = ce2_r * $signed({1'b0, up_r[2]});
    f11_div   = btpc_pkg::sdiv_p2(64'(f11_2_r), 16);
    o1_3_nxt  = $signed({1'b0, coef.p5, 47'd0}) + f6_2_r;
    s1_3_nxt  = (64'(p1m) <<< 46) + e2_2_r;
    // stage 4
    c11_full  = b11_3_r * $signed({1'b0, up_r[3]});
    // stage 5: coefficient products, reciprocal multiply for the divide by ten
    d8_full   = c4_r * coef.p8;
    b4_full   = c4_r * coef.p4;
    absd      = d4_r[63] ? -d4_r : d4_r;
    mag       = absd[45:0];
    qlo5_nxt  = mag[22:0] * btpc_pkg::RECIP10;
    qhi5_nxt  = mag[45:23] * btpc_pkg::RECIP10;
    // stage 6
    qsum      = 93'(qlo5_r) + (93'(qhi5_r) << 23);
    // stage 7
    dq7_nxt   = neg6_r ? -$signed({1'b0, q6_r}) : $signed({1'b0, q6_r});
    // stage 8
    ee_full   = dq7_r * $signed({1'b0, up_r[7]});
    sa_div    = btpc_pkg::sdiv_p2(s3_7_r, 24);
    // stage 9
    aa_full   = sa8_r * $signed({1'b0, up_r[8]});
    // stage 12: scale by 25 / 2^40 and clamp
    lo25      = 45'(sum11_r[39:0]) * 45'd25;
    pf        = 34'(sum11_r[62:40]) * 34'd25 + 34'(lo25[44:40]);
    if (sum11_r[63]) begin
      press_nxt = '0;
      clamp_nxt = 1'b1;
    end else if (pf > 34'h0_FFFF_FFFF) begin
      press_nxt = '1;
      clamp_nxt = 1'b1;
    end else begin
      press_nxt = pf[31:0];
      clamp_nxt = 1'b0;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-2:0], accept};
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    up_r[0]   <= in_item.up;
    for (int i = 1; i < NUP; i++) up_r[i] <= up_r[i-1];
    temp_r[0] <= in_item.temp;
    for (int i = 1; i < NSTG; i++) temp_r[i] <= temp_r[i-1];
    // stage 0..1
    tl0_r     <= in_item.tl;
    tl1_r     <= tl0_r;
    sq1_r     <= sq1_nxt;
    m6_1_r    <= m6_1_nxt;
    m2_1_r    <= m2_1_nxt;
    m10_1_r   <= m10_1_nxt;
    ff1_r     <= ff1_nxt;
    // stage 2
    cplo2_r   <= cplo2_nxt;
    cphi2_r   <= cphi2_nxt;
    e7_2_r    <= e7_2_nxt;
    d3_2_r    <= d3_2_nxt;
    ce2_r     <= ce2_nxt;
    f11_2_r   <= f11_2_nxt;
    f6_2_r    <= 64'(m6_1_r) <<< 22;
    e2_2_r    <= 64'(m2_1_r) <<< 21;
    // stage 3
    cp3_r     <= cp3_nxt;
    dd3_r     <= 64'(dd_full);
    b11_3_r   <= f11_div[40:0];
    o1_3_r    <= o1_3_nxt;
    s1_3_r    <= s1_3_nxt;
    e7_3_r    <= e7_2_r <<< 4;
    d3_3_r    <= d3_2_r <<< 2;
    // stage 4
    c4_r      <= btpc_pkg::sdiv_p2(cp3_r, 8);
    d4_r      <= btpc_pkg::sdiv_p2(dd3_r, 13);
    c11_4_r   <= 64'(c11_full);
    o2_4_r    <= o1_3_r + e7_3_r;
    s2_4_r    <= s1_3_r + d3_3_r;
    // stage 5
    d8_5_r    <= 64'(d8_full);
    b4_5_r    <= 64'(b4_full);
    neg5_r    <= d4_r[63];
    qlo5_r    <= qlo5_nxt;
    qhi5_r    <= qhi5_nxt;
    cc5_r     <= btpc_pkg::sdiv_p2(c11_4_r, 7);
    o2_5_r    <= o2_4_r;
    s2_5_r    <= s2_4_r;
    // stage 6
    q6_r      <= qsum[92:btpc_pkg::RECIP10_SHIFT];
    neg6_r    <= neg5_r;
    d6_r      <= btpc_pkg::sdiv_p2(d8_5_r, 5);
    b4d6_r    <= btpc_pkg::sdiv_p2(b4_5_r, 5);
    cc6_r     <= cc5_r;
    o2_6_r    <= o2_5_r;
    s2_6_r    <= s2_5_r;
    // stage 7: offset and sensitivity complete
    dq7_r     <= dq7_nxt;
    o3_7_r    <= o2_6_r + d6_r;
    s3_7_r    <= s2_6_r + b4d6_r;
    cc7_r     <= cc6_r;
    // stage 8
    ee8_r     <= 64'(ee_full);
    sa8_r     <= sa_div[39:0];
    off4_8_r  <= btpc_pkg::sdiv_p2(o3_7_r, 2);
    cc8_r     <= cc7_r;
    // stage 9
    e9_r      <= btpc_pkg::sdiv_p2(ee8_r, 9);
    aa9_r     <= 64'(aa_full);
    off4_9_r  <= off4_8_r;
    cc9_r     <= cc8_r;
    // stage 10
    e10_r     <= (e9_r <<< 3) + (e9_r <<< 1);
    sum1_10_r <= off4_9_r + aa9_r;
    cc10_r    <= cc9_r;
    // stage 11
    sum11_r   <= sum1_10_r + cc10_r + e10_r;
    // stage 12
    press12_r <= press_nxt;
    clamp12_r <= clamp_nxt;
  end

  assign push         = vld_r[NSTG-1];
  assign item.up      = '0;
  assign item.tl      = '0;
  assign item.temp    = temp_r[NSTG-1];
  assign item.press   = press12_r;
  assign item.clamped = clamp12_r;

endmodule

>>> verif/baro_temp_press_compensation_checker.sv
// result checker for the barometric compensation block
// watches the input and result queues, predicts each result and compares
`timescale 1ns / 100ps

module baro_temp_press_compensation_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  logic [23:0]        in_raw_pressure,
  input  logic [23:0]        in_raw_temperature,
  input  logic               pop,
  input  logic               empty,
  input  logic signed [20:0] out_temperature_centi,
  input  logic [31:0]        out_pressure_centi,
  input  logic               out_pressure_clamped,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [20:0] temp;
    logic [31:0]        press;
    logic               clamped;
  } comp_t;

  logic [63:0] cal_low, cal_mid;
  logic [39:0] cal_high;
  comp_t       expected_q[$];

  assign pending = expected_q.size();

  // truncating signed division by 2^k
  function automatic longint trunc_shr(input longint x, input int k);
    longint q;
    q = x >>> k;
    if (x < 0 && (x & ((64'sd1 <<< k) - 1)) != 0) q = q + 1;
    return q;
  endfunction

  function automatic comp_t compensate(input logic [23:0] rp, input logic [23:0] rt);
    logic [167:0] cb;
    longint up, ut, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    longint a, b, c, d, e, f, tl, off, sens, sum;
    logic [63:0] su, pr;
    comp_t r;
    cb = {cal_high, cal_mid, cal_low};
    up = longint'(rp); ut = longint'(rt);
    t1 = longint'(cb[15:0]);   t2 = longint'(cb[31:16]);
    t3 = longint'($signed(cb[39:32]));
    p1 = longint'($signed(cb[55:40]));  p2 = longint'($signed(cb[71:56]));
    p3 = longint'($signed(cb[79:72]));  p4 = longint'($signed(cb[87:80]));
    p5 = longint'(cb[103:88]);          p6 = longint'(cb[119:104]);
    p7 = longint'($signed(cb[127:120])); p8 = longint'($signed(cb[135:128]));
    p9 = longint'($signed(cb[151:136])); p10 = longint'($signed(cb[159:152]));
    p11 = longint'($signed(cb[167:160]));
    // temperature
    a = ut - 256 * t1;
    b = t2 * a;
    c = a * a * t3;
    tl = trunc_shr(b * 262144 + c, 32);
    r.temp = 21'(trunc_shr(tl * 25, 14));
    // offset
    a = tl * tl;
    b = trunc_shr(a, 6);
    c = trunc_shr(b * tl, 8);
    d = trunc_shr(p8 * c, 5);
    e = p7 * a * 16;
    f = p6 * tl * 4194304;
    off = p5 * 64'sd140737488355328 + d + e + f;
    // sensitivity
    b = trunc_shr(p4 * c, 5);
    d = p3 * a * 4;
    e = (p2 - 16384) * tl * 2097152;
    sens = (p1 - 16384) * 64'sd70368744177664 + b + d + e;
    // pressure polynomial
    a = trunc_shr(sens, 24) * up;
    b = p10 * tl;
    c = b + 65536 * p9;
    d = trunc_shr(c * up, 13);
    e = trunc_shr(up * (d / 10), 9) * 10;
    f = up * up;
    b = trunc_shr(p11 * f, 16);
    c = trunc_shr(b * up, 7);
    sum = trunc_shr(off, 2) + a + e + c;
    r.clamped = 1'b0;
    r.press = '0;
    if (sum < 0) begin
      r.clamped = 1'b1;
    end else begin
      su = sum;
      pr = 25 * (su >> 40) + (({24'd0, su[39:0]} * 25) >> 40);
      if (pr > 64'hFFFF_FFFF) begin
        r.press = '1;
        r.clamped = 1'b1;
      end else begin
        r.press = pr[31:0];
      end
    end
    return r;
  endfunction

  // register shadow, prediction and comparison
  always @(posedge clk) begin
    comp_t want;
    int    errs;
    errs = 0;
    if (!rst_n) begin
      cal_low <= '0; cal_mid <= '0; cal_high <= '0;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[4:3])
          btpc_pkg::REG_LOW:  cal_low  <= pwdata;
          btpc_pkg::REG_MID:  cal_mid  <= pwdata;
          btpc_pkg::REG_HIGH: cal_high <= pwdata[39:0];
          default: ;
        endcase
      end
      if (push && !full) expected_q.push_back(compensate(in_raw_pressure, in_raw_temperature));
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected");
          errs = errs + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.temp !== out_temperature_centi) begin
            $error("temperature_centi expected %0d actual %0d", want.temp,
                   out_temperature_centi);
            errs = errs + 1;
          end
          if (want.press !== out_pressure_centi) begin
            $error("pressure_centi expected %0d actual %0d", want.press,
                   out_pressure_centi);
            errs = errs + 1;
          end
          if (want.clamped !== out_pressure_clamped) begin
            $error("pressure_clamped expected %0d actual %0d", want.clamped,
                   out_pressure_clamped);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

>>> verif/baro_temp_press_compensation_test.sv
// stimulus top for the barometric compensation block
// depends on btpc_pkg, the block and baro_temp_press_compensation_checker
`timescale 1ns / 100ps

module baro_temp_press_compensation_test;

  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 5000;

  logic clk = 1'b0, rst_n = 1'b0;
  logic push = 1'b0, pop = 1'b0;
  logic full, empty, pready;
  logic [23:0] in_raw_pressure = '0, in_raw_temperature = '0;
  logic signed [20:0] out_temperature_centi;
  logic [31:0] out_pressure_centi;
  logic out_pressure_clamped;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0, prdata;
  int fail_count, pending;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;
  bit calm = 1'b0;

  always #4 clk = ~clk;

  baro_temp_press_compensation u_dut (.*);

  baro_temp_press_compensation_checker u_checker (.*);

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("FAIL baro_temp_press_compensation");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off
  always @(negedge clk) begin
    if (!rst_n || hold_off) pop <= 1'b0;
    else pop <= calm || ($urandom_range(99) >= 9);
  end

  task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_sample(input logic [23:0] rp, input logic [23:0] rt);
    while (!calm && $urandom_range(99) < 9) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_raw_pressure <= rp;
    in_raw_temperature <= rt;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_calib(input logic [63:0] lo, input logic [63:0] mid,
                            input logic [39:0] hi);
    reg_write(btpc_pkg::REG_LOW, lo);
    reg_write(btpc_pkg::REG_MID, mid);
    reg_write(btpc_pkg::REG_HIGH, {24'd0, hi});
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset calibration, field extremes
    send_sample(24'd0, 24'd0);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'd0);
    send_sample(24'd0, 24'hFFFFFF);
    settle();

    // typical calibration, then all ones and sign-bit extremes
    load_calib(64'h1D_0C_B0_6A_F3_6B_4A_2B, 64'hF5_48_A4_1E_0E_F6_1A_E7,
               40'hF3_C6_04_79_3C);
    send_sample(24'h6B_2A00, 24'h82_0000);
    send_sample(24'h7A_0000, 24'h7F_FFFF);
    send_sample(24'd1, 24'h80_0000);
    send_sample(24'hFFFFFF, 24'h400000);
    settle();
    load_calib('1, '1, '1);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h000000, 24'h123456);
    send_sample(24'h800000, 24'd0);
    settle();
    load_calib(64'h80_80_80_00_80_7F_FF_FF, 64'h7F_7F_FF_FF_80_80_80_00,
               40'h80_80_80_00_80);
    send_sample(24'hFFFFFF, 24'd0);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h555555, 24'hAAAAAA);
    settle();

    // random phases with random calibration
    for (int ph = 0; ph < 6; ph++) begin
      load_calib({$urandom, $urandom}, {$urandom, $urandom},
                 {8'($urandom_range(255)), $urandom});
      calm = (ph == 2);
      if (ph == 3) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (150) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < 72; i++) send_sample(24'($urandom), 24'($urandom));
      calm = 1'b0;
      settle();
    end

    stim_done = 1'b1;
    if (fail_count == 0) $display("PASS baro_temp_press_compensation");
    else $display("FAIL baro_temp_press_compensation");
    $finish;
  end
endmodule
